FILE: rtl/qet_pkg.sv
package qet_pkg;

  // Field widths of the two channels and the configuration port.
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Up to this many results follow from one input byte.
  localparam int MAX_RESULTS = 3;
  localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

  // Default depth of the plan queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_BYTE      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TOKEN_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LINE_END  = 2'd2;

  // One result as the back end sends it out.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
  } qet_result_t;

  // Everything one input byte causes: a result count and the results in order.
  typedef struct packed {
    logic [COUNT_W-1:0]                  count;
    qet_result_t [MAX_RESULTS-1:0]       slot;
  } qet_plan_t;

endpackage

FILE: rtl/qet_in_if.sv
interface qet_in_if;
  logic                       valid;
  logic                       ready;
  logic [qet_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: rtl/qet_out_if.sv
interface qet_out_if;
  logic                       valid;
  logic                       ready;
  logic [qet_pkg::KIND_W-1:0] kind;
  logic [qet_pkg::BYTE_W-1:0] out_byte;
  logic                       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

FILE: rtl/quote_escape_tokenizer.sv
// Path: an accepted byte's plan goes into the plan queue; the back end then loads each
// result into the output register. Throughput: one input byte per cycle while each byte
// yields at most one result and the output is not stalled. The four-entry plan queue
// absorbs multi-result bursts before input ready drops; resultless bytes queue nothing.
// Reset: synchronous, active low; the parse state clears and the delimiters return to
// space, tab, carriage return and line feed with all four in use. No clearing pass.
module quote_escape_tokenizer #(
  parameter int QUEUE_DEPTH = qet_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [qet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qet_pkg::CFG_DATA_W-1:0] cfg_data,
  qet_in_if.sink                         in_ch,
  qet_out_if.source                      out_ch
);
  import qet_pkg::*;

  logic      in_fire;
  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;
  qet_plan_t plan;
  qet_plan_t head_plan;

  // The front keeps taking beats while the queue has room.
  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  qet_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_byte   (in_ch.in_byte),
    .push      (push),
    .plan      (plan)
  );

  qet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_plan (plan),
    .pop       (pop),
    .head_plan (head_plan),
    .empty     (q_empty),
    .full      (q_full)
  );

  qet_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!q_empty),
    .head_plan  (head_plan),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // A zero byte always ends a line, so its beat must queue a plan.
  a_zero_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.in_byte == '0)) |-> push)
    else $error("zero byte accepted without a queued plan");

  // The end of a line is always the last result of its byte.
  a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == KIND_LINE_END)) |-> out_ch.last)
    else $error("line end not marked last");

  // Only token bytes carry a character.
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind != KIND_BYTE)) |-> (out_ch.out_byte == '0))
    else $error("marker result carries a nonzero byte");

  // A pop only happens on a nonempty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

FILE: rtl/qet_front.sv
module qet_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [qet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qet_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_fire,
  input  logic [qet_pkg::BYTE_W-1:0]     in_byte,
  output logic                           push,
  output qet_pkg::qet_plan_t             plan
);
  import qet_pkg::*;

  // Parse phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_TOKEN  = 2'd1;
  localparam logic [1:0] PH_QUOTED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_COUNT = 3'd4;

  localparam int NUM_DELIMS     = 4;
  localparam int MAX_DELIMITERS = 4;
  localparam int DCNT_W         = 3;

  localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;

  logic [BYTE_W-1:0] delim_r [NUM_DELIMS];
  logic [DCNT_W-1:0] delim_count_r;

  logic [1:0] phase_r, phase_nxt;
  logic       mtq_r, mtq_nxt;
  logic       esc_r, esc_nxt;
  logic       qp_r, qp_nxt;

  logic [DCNT_W-1:0] eff_count;
  logic              is_delim;
  logic [1:0]        ph_v;
  logic              handled;
  qet_plan_t         plan_v;

  // Append one result to a plan.
  function automatic qet_plan_t plan_put(qet_plan_t p, logic [KIND_W-1:0] k,
                                         logic [BYTE_W-1:0] b);
    qet_plan_t q;
    q = p;
    q.slot[q.count[1:0]].kind = k;
    q.slot[q.count[1:0]].data = (k == KIND_BYTE) ? b : '0;
    q.count = q.count + COUNT_W'(1);
    return q;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r[0]    <= 8'd32;
      delim_r[1]    <= 8'd9;
      delim_r[2]    <= 8'd13;
      delim_r[3]    <= 8'd10;
      delim_count_r <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELIM_0:     delim_r[0]    <= cfg_data;
        REG_DELIM_1:     delim_r[1]    <= cfg_data;
        REG_DELIM_2:     delim_r[2]    <= cfg_data;
        REG_DELIM_3:     delim_r[3]    <= cfg_data;
        REG_DELIM_COUNT: delim_count_r <= cfg_data[DCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Parallel delimiter match; a count above the lane count saturates.
  always_comb begin
    eff_count = (delim_count_r > DCNT_W'(MAX_DELIMITERS)) ? DCNT_W'(MAX_DELIMITERS)
                                                          : delim_count_r;
    is_delim = 1'b0;
    for (int i = 0; i < NUM_DELIMS; i++) begin
      if ((DCNT_W'(i) < eff_count) && (delim_r[i] == in_byte)) begin
        is_delim = 1'b1;
      end
    end
    if (in_byte == CH_NUL) begin
      is_delim = 1'b0;
    end
  end

  // Classify the byte into a plan of results and the next parse state.
  always_comb begin
    phase_nxt = phase_r;
    mtq_nxt   = mtq_r;
    esc_nxt   = esc_r;
    qp_nxt    = qp_r;
    plan_v    = '0;
    handled   = 1'b0;
    ph_v      = phase_r;

    if (esc_r) begin
      // The byte after a backslash is taken literally, except that a zero byte still ends the line.
      esc_nxt = 1'b0;
      if (in_byte == CH_NUL) begin
        if (phase_r != PH_IDLE) begin
          plan_v = plan_put(plan_v, KIND_TOKEN_END, '0);
        end
        plan_v    = plan_put(plan_v, KIND_LINE_END, '0);
        phase_nxt = PH_IDLE;
        mtq_nxt   = 1'b0;
        qp_nxt    = 1'b0;
      end else begin
        plan_v = plan_put(plan_v, KIND_BYTE, in_byte);
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_TOKEN;
          mtq_nxt   = 1'b0;
        end
      end
    end else begin
      // A quote seen inside a quoted section is either doubled or closing.
      if (qp_r) begin
        qp_nxt = 1'b0;
        if (in_byte == CH_QUOTE) begin
          plan_v  = plan_put(plan_v, KIND_BYTE, CH_QUOTE);
          handled = 1'b1;
        end else begin
          if (mtq_r) begin
            plan_v = plan_put(plan_v, KIND_BYTE, CH_QUOTE);
          end
          ph_v      = PH_TOKEN;
          phase_nxt = PH_TOKEN;
        end
      end

      if (!handled) begin
        unique case (ph_v)
          PH_IDLE: begin
            if (in_byte == CH_NUL) begin
              plan_v = plan_put(plan_v, KIND_LINE_END, '0);
              mtq_nxt = 1'b0;
              qp_nxt  = 1'b0;
            end else if (in_byte == CH_QUOTE) begin
              phase_nxt = PH_QUOTED;
              mtq_nxt   = 1'b0;
            end else if (in_byte == CH_BACKSLASH) begin
              esc_nxt = 1'b1;
            end else if (!is_delim) begin
              plan_v    = plan_put(plan_v, KIND_BYTE, in_byte);
              phase_nxt = PH_TOKEN;
              mtq_nxt   = 1'b0;
            end
          end
          PH_TOKEN: begin
            if (in_byte == CH_NUL) begin
              plan_v    = plan_put(plan_v, KIND_TOKEN_END, '0);
              plan_v    = plan_put(plan_v, KIND_LINE_END, '0);
              phase_nxt = PH_IDLE;
              mtq_nxt   = 1'b0;
              qp_nxt    = 1'b0;
            end else if (in_byte == CH_BACKSLASH) begin
              esc_nxt = 1'b1;
            end else if (in_byte == CH_QUOTE) begin
              plan_v    = plan_put(plan_v, KIND_BYTE, CH_QUOTE);
              mtq_nxt   = 1'b1;
              phase_nxt = PH_QUOTED;
            end else if (is_delim) begin
              plan_v    = plan_put(plan_v, KIND_TOKEN_END, '0);
              phase_nxt = PH_IDLE;
              mtq_nxt   = 1'b0;
            end else begin
              plan_v = plan_put(plan_v, KIND_BYTE, in_byte);
            end
          end
          default: begin
            // Inside a quoted section delimiters are ordinary bytes.
            if (in_byte == CH_NUL) begin
              plan_v    = plan_put(plan_v, KIND_TOKEN_END, '0);
              plan_v    = plan_put(plan_v, KIND_LINE_END, '0);
              phase_nxt = PH_IDLE;
              mtq_nxt   = 1'b0;
              qp_nxt    = 1'b0;
            end else if (in_byte == CH_QUOTE) begin
              qp_nxt = 1'b1;
            end else if (in_byte == CH_BACKSLASH) begin
              esc_nxt = 1'b1;
            end else begin
              plan_v = plan_put(plan_v, KIND_BYTE, in_byte);
            end
          end
        endcase
      end
    end
  end

  // Parse state advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mtq_r   <= 1'b0;
      esc_r   <= 1'b0;
      qp_r    <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      mtq_r   <= mtq_nxt;
      esc_r   <= esc_nxt;
      qp_r    <= qp_nxt;
    end
  end

  // Only plans that carry results go into the queue.
  assign plan = plan_v;
  assign push = in_fire && (plan_v.count != '0);

endmodule

FILE: rtl/qet_queue.sv
module qet_queue #(
  parameter int DEPTH = qet_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qet_pkg::qet_plan_t push_plan,
  input  logic               pop,
  output qet_pkg::qet_plan_t head_plan,
  output logic               empty,
  output logic               full
);
  import qet_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qet_plan_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Plan storage; entries carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_plan;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign head_plan = mem_r[rd_ptr_r];
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));

endmodule

FILE: rtl/qet_back.sv
module qet_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  qet_pkg::qet_plan_t head_plan,
  output logic               pop,
  qet_out_if.source          out_ch
);
  import qet_pkg::*;

  logic [COUNT_W-1:0] sub_r;
  logic               out_valid_r;
  logic [KIND_W-1:0]  kind_r;
  logic [BYTE_W-1:0]  byte_r;
  logic               last_r;

  logic               load;
  logic               last_slot;
  qet_result_t        cur;

  // Walk the results of the head plan, one per cycle into the output register while the output is not stalled.
  assign load      = head_valid && (!out_valid_r || out_ch.ready);
  assign last_slot = (sub_r == head_plan.count - COUNT_W'(1));
  assign cur       = head_plan.slot[sub_r[1:0]];
  assign pop       = load && last_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        sub_r       <= last_slot ? '0 : sub_r + COUNT_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= cur.kind;
      byte_r <= cur.data;
      last_r <= last_slot;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.last     = last_r;

endmodule

FILE: tb/tb_quote_escape_tokenizer.sv
module tb_quote_escape_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import qet_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int MAX_IDLE     = 17;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 400;
  localparam int MAX_REPORTS  = 10;
  localparam int MAX_DELIMS   = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_COUNT = 3'd4;

  // Special characters of the line format.
  localparam logic [BYTE_W-1:0] CH_LINE_END  = 8'h00;
  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;

  // Parse phases of the tokenizer.
  localparam logic [1:0] PH_BEFORE_TOKEN = 2'd0;
  localparam logic [1:0] PH_IN_TOKEN     = 2'd1;
  localparam logic [1:0] PH_IN_QUOTES    = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } token_event_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  qet_in_if  in_ch ();
  qet_out_if out_ch ();

  quote_escape_tokenizer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Expected token events, oldest first.
  token_event_t token_events_q[$];

  // Tokenizer state and delimiter settings as the testbench tracks them.
  logic [BYTE_W-1:0] delim_tab [0:MAX_DELIMS-1];
  logic [2:0]        delim_cnt;
  logic [1:0]        ph;
  logic              mid_quote;
  logic              esc_pend;
  logic              quote_pend;

  // Events caused by the byte under prediction.
  logic [KIND_W-1:0] staged_kind [0:MAX_RESULTS-1];
  logic [BYTE_W-1:0] staged_data [0:MAX_RESULTS-1];
  int                staged_n;

  bit idle_in;
  bit idle_out;
  int bytes_sent;
  int error_count;
  int quiet_cycles;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int active_delims();
    return (delim_cnt > MAX_DELIMS) ? MAX_DELIMS : int'(delim_cnt);
  endfunction

  function automatic bit is_delimiter(input logic [BYTE_W-1:0] c);
    int n;
    n = active_delims();
    if (c == CH_LINE_END) return 1'b0;
    for (int i = 0; i < n; i++)
      if (delim_tab[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  task automatic stage_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data);
    staged_kind[staged_n] = kind;
    staged_data[staged_n] = (kind == KIND_BYTE) ? data : '0;
    staged_n++;
  endtask

  // End of line: close any open token and return to the line start state.
  task automatic close_line(input bit token_open);
    if (token_open) stage_result(KIND_TOKEN_END, '0);
    stage_result(KIND_LINE_END, '0);
    ph         = PH_BEFORE_TOKEN;
    mid_quote  = 1'b0;
    esc_pend   = 1'b0;
    quote_pend = 1'b0;
  endtask

  // Work out the token events one accepted byte causes and queue them.
  task automatic predict_tokens(input logic [BYTE_W-1:0] c);
    bit           handled;
    token_event_t ev;
    handled  = 1'b0;
    staged_n = 0;
    if (esc_pend) begin
      esc_pend = 1'b0;
      if (c == CH_LINE_END) begin
        close_line(ph != PH_BEFORE_TOKEN);
      end else begin
        stage_result(KIND_BYTE, c);
        if (ph == PH_BEFORE_TOKEN) begin
          ph        = PH_IN_TOKEN;
          mid_quote = 1'b0;
        end
      end
    end else begin
      // A quote inside quotes is either doubled or closes the section.
      if (quote_pend) begin
        quote_pend = 1'b0;
        if (c == CH_QUOTE) begin
          stage_result(KIND_BYTE, CH_QUOTE);
          handled = 1'b1;
        end else begin
          if (mid_quote) stage_result(KIND_BYTE, CH_QUOTE);
          ph = PH_IN_TOKEN;
        end
      end
      if (!handled) begin
        case (ph)
          PH_BEFORE_TOKEN: begin
            if (c == CH_LINE_END) begin
              close_line(1'b0);
            end else if (c == CH_QUOTE) begin
              ph        = PH_IN_QUOTES;
              mid_quote = 1'b0;
            end else if (c == CH_BACKSLASH) begin
              esc_pend = 1'b1;
            end else if (!is_delimiter(c)) begin
              stage_result(KIND_BYTE, c);
              ph        = PH_IN_TOKEN;
              mid_quote = 1'b0;
            end
          end
          PH_IN_TOKEN: begin
            if (c == CH_LINE_END) begin
              close_line(1'b1);
            end else if (c == CH_BACKSLASH) begin
              esc_pend = 1'b1;
            end else if (c == CH_QUOTE) begin
              stage_result(KIND_BYTE, CH_QUOTE);
              mid_quote = 1'b1;
              ph        = PH_IN_QUOTES;
            end else if (is_delimiter(c)) begin
              stage_result(KIND_TOKEN_END, '0);
              ph        = PH_BEFORE_TOKEN;
              mid_quote = 1'b0;
            end else begin
              stage_result(KIND_BYTE, c);
            end
          end
          default: begin
            if (c == CH_LINE_END) close_line(1'b1);
            else if (c == CH_QUOTE) quote_pend = 1'b1;
            else if (c == CH_BACKSLASH) esc_pend = 1'b1;
            else stage_result(KIND_BYTE, c);
          end
        endcase
      end
    end
    for (int i = 0; i < staged_n; i++) begin
      ev.kind = staged_kind[i];
      ev.data = staged_data[i];
      ev.last = (i == staged_n - 1);
      token_events_q.push_back(ev);
    end
  endtask

  // Predict on every input beat.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) predict_tokens(in_ch.in_byte);
  end

  // Compare every output beat with the oldest expected event.
  always @(posedge clk) begin : result_check
    token_event_t exp_ev;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (token_events_q.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result: kind %0d byte 0x%02h last %0b",
                   out_ch.kind, out_ch.out_byte, out_ch.last);
        error_count++;
      end else begin
        exp_ev = token_events_q.pop_front();
        if (out_ch.kind !== exp_ev.kind || out_ch.out_byte !== exp_ev.data ||
            out_ch.last !== exp_ev.last) begin
          if (error_count < MAX_REPORTS)
            $display({"mismatch: expected kind %0d byte 0x%02h last %0b, ",
                      "got kind %0d byte 0x%02h last %0b"},
                     exp_ev.kind, exp_ev.data, exp_ev.last,
                     out_ch.kind, out_ch.out_byte, out_ch.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any beat ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: a random stall before each beat when idling is on.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = idle_out ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Send one byte after a random gap; returns at the edge where it is accepted.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = idle_in ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_line_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_LINE_END);
  endtask

  // Mostly text, delimiters, quotes and backslashes; now and then a stray zero.
  function automatic logic [BYTE_W-1:0] random_text_byte();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    n    = active_delims();
    if (pick < 35) return BYTE_W'($urandom_range(8'h21, 8'h7E));
    if (pick < 55) return (n == 0) ? 8'h20 : delim_tab[$urandom_range(0, n - 1)];
    if (pick < 68) return CH_QUOTE;
    if (pick < 76) return CH_BACKSLASH;
    if (pick < 97) return BYTE_W'($urandom_range(1, 255));
    return CH_LINE_END;
  endfunction

  task automatic send_random_line();
    int len;
    len      = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 12);
    idle_in  = ($urandom_range(0, 3) != 0);
    idle_out = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < len; i++) send_byte(random_text_byte());
    send_byte(CH_LINE_END);
  endtask

  // Let every expected event arrive and the block settle. The first edge lets
  // the prediction of the last accepted beat land in the queue.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (token_events_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller lowers the write enable after the last one.
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_DELIM_0:     delim_tab[0] = data;
      REG_DELIM_1:     delim_tab[1] = data;
      REG_DELIM_2:     delim_tab[2] = data;
      REG_DELIM_3:     delim_tab[3] = data;
      REG_DELIM_COUNT: delim_cnt    = data[2:0];
      default: ;
    endcase
  endtask

  task automatic set_delimiters(input logic [BYTE_W-1:0] d0, input logic [BYTE_W-1:0] d1,
                                input logic [BYTE_W-1:0] d2, input logic [BYTE_W-1:0] d3,
                                input logic [2:0] cnt);
    wait_for_drain();
    cfg_put(REG_DELIM_0, d0);
    cfg_put(REG_DELIM_1, d1);
    cfg_put(REG_DELIM_2, d2);
    cfg_put(REG_DELIM_3, d3);
    cfg_put(REG_DELIM_COUNT, {5'd0, cnt});
    cfg_we <= 1'b0;
  endtask

  // Short lines on the reset delimiters covering the corner cases.
  task automatic test_directed_lines();
    idle_in  = 1'b0;
    idle_out = 1'b0;
    // Empty line, then a line of delimiters only.
    send_line_text("");
    send_line_text(" ");
    // Empty quoted token, then mid-token quotes with a doubled quote and a
    // closing quote right before the line end.
    idle_in  = 1'b1;
    idle_out = 1'b1;
    send_line_text("\"\" a\"b\"\"c\"");
    // Escape before any token, extreme byte values, backslash before line end.
    idle_in  = 1'b0;
    send_line_text("\\\"\377\001\\");
    send_line_text("\\");
    // Quoted section with a literal delimiter, closed by a delimiter.
    idle_in  = 1'b1;
    idle_out = 1'b0;
    send_line_text("\"x \200\"\r");
  endtask

  // A series of delimiter settings, the extremes among them.
  task automatic test_delimiter_settings();
    // No delimiters at all.
    set_delimiters(8'd32, 8'd9, 8'd13, 8'd10, 3'd0);
    repeat (2) send_random_line();
    // A single comma.
    set_delimiters(8'h2C, 8'd32, 8'd9, 8'd13, 3'd1);
    repeat (2) send_random_line();
    // A zero delimiter byte never matches.
    set_delimiters(8'h00, 8'h3B, 8'd32, 8'd9, 3'd2);
    repeat (2) send_random_line();
    // Count above the maximum; quote and backslash listed as delimiters.
    set_delimiters(CH_QUOTE, CH_BACKSLASH, 8'hFF, 8'h01, 3'd7);
    repeat (2) send_random_line();
    set_delimiters(8'h80, 8'h7F, 8'h41, 8'hFE, 3'd3);
    repeat (2) send_random_line();
    set_delimiters(8'd32, 8'd9, 8'd13, 8'd10, 3'd4);
    repeat (2) send_random_line();
  endtask

  function automatic logic [BYTE_W-1:0] random_delim_byte();
    case ($urandom_range(0, 15))
      0:       return 8'd32;
      1:       return 8'd9;
      2:       return 8'h2C;
      3:       return CH_QUOTE;
      4:       return CH_BACKSLASH;
      5:       return 8'h00;
      6, 7:    return BYTE_W'($urandom_range(8'h21, 8'h7E));
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Random lines under random delimiter settings.
  task automatic test_random_lines();
    int target;
    for (int chunk = 0; chunk < 3; chunk++) begin
      set_delimiters(random_delim_byte(), random_delim_byte(), random_delim_byte(),
                     random_delim_byte(), 3'($urandom_range(0, 7)));
      target = bytes_sent + 55;
      while (bytes_sent < target) send_random_line();
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    delim_tab[0]  = 8'd32;
    delim_tab[1]  = 8'd9;
    delim_tab[2]  = 8'd13;
    delim_tab[3]  = 8'd10;
    delim_cnt     = 3'd4;
    ph            = PH_BEFORE_TOKEN;
    mid_quote     = 1'b0;
    esc_pend      = 1'b0;
    quote_pend    = 1'b0;
    idle_in       = 1'b0;
    idle_out      = 1'b0;
    bytes_sent    = 0;
    error_count   = 0;
    quiet_cycles  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lines();
    test_delimiter_settings();
    test_random_lines();
    wait_for_drain();

    if (error_count == 0 && token_events_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
